/* rtl/adjacent_box_merger_defines.svh */
// Assertion macros for the RTL, used by abm_ctrl.
`ifndef ADJACENT_BOX_MERGER_DEFINES_SVH
`define ADJACENT_BOX_MERGER_DEFINES_SVH

// Checked only while out of reset.
`define ABM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define ABM_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/abm_pkg.sv */
`timescale 1ns / 1ps
package abm_pkg;

	localparam int MAX_BOXES = 32;
	localparam int IDX_W     = $clog2(MAX_BOXES);
	localparam int CNT_W     = $clog2(MAX_BOXES + 1);

	localparam int COORD_W   = 12;
	localparam int SCORE_W   = 8;
	localparam int MARGIN_W  = 8;
	localparam int REG_IDX_W = 1;

	localparam logic [COORD_W-1:0] SIZE_MAX = {COORD_W{1'b1}};

	localparam logic [MARGIN_W-1:0] MARGIN_X_RST = 8'd16;
	localparam logic [MARGIN_W-1:0] MARGIN_Y_RST = 8'd0;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_MARGIN_X = 1'b0,
		REG_MARGIN_Y = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [COORD_W-1:0] l;
		logic [COORD_W-1:0] t;
		logic [COORD_W-1:0] w;
		logic [COORD_W-1:0] h;
		logic [SCORE_W-1:0] s;
	} box_t;

	// store write source
	typedef enum logic [1:0] {
		WR_IN   = 2'd0,
		WR_A    = 2'd1,
		WR_MOVE = 2'd2
	} wr_sel_t;

	typedef struct packed {
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		wr_sel_t          wr_sel;
		logic             load_a;
		logic             eval;
		logic             merge;
	} cmd_t;

	typedef struct packed {
		logic hit;
	} status_t;

endpackage

/* rtl/adjacent_box_merger.sv */
`timescale 1ns / 1ps
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_stall   | box_left box_top box_width box_height box_score final_box
// out     | output    | out_valid / out_stall | out_left out_top out_width out_height out_score end_of_set overflowed
// cfg     | input     | cfg_wr_en             | cfg_index cfg_data
//
// Load: one word per cycle into the box store; the word with final_box set starts the merge.
// Merge: each outer entry runs S_OUTER (read), S_A_WAIT (load A and window), S_INNER (write back);
//   inner tests S_INNER, S_B_WAIT, S_B_EVAL, S_MOVE on a move; in_stall is high until the last result is taken.
// Emit: per result a store read, then the output register held until out_stall is low.
// Reset (arst_n, async) empties the set and loads margin_x = 16, margin_y = 0.
module adjacent_box_merger (
	input  logic                               clk,
	input  logic                               arst_n,

	input  logic                               cfg_wr_en,
	input  logic [abm_pkg::REG_IDX_W-1:0]      cfg_index,
	input  logic [abm_pkg::MARGIN_W-1:0]       cfg_data,

	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [abm_pkg::COORD_W-1:0]        box_left,
	input  logic [abm_pkg::COORD_W-1:0]        box_top,
	input  logic [abm_pkg::COORD_W-1:0]        box_width,
	input  logic [abm_pkg::COORD_W-1:0]        box_height,
	input  logic [abm_pkg::SCORE_W-1:0]        box_score,
	input  logic                               final_box,

	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [abm_pkg::COORD_W-1:0]        out_left,
	output logic [abm_pkg::COORD_W-1:0]        out_top,
	output logic [abm_pkg::COORD_W-1:0]        out_width,
	output logic [abm_pkg::COORD_W-1:0]        out_height,
	output logic [abm_pkg::SCORE_W-1:0]        out_score,
	output logic                               end_of_set,
	output logic                               overflowed
);

	abm_pkg::cmd_t    cmd;
	abm_pkg::status_t status;
	abm_pkg::box_t    rd_box;

	// sequencer: load, pairwise merge scan, emission
	abm_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.final_box  (final_box),
		.in_stall   (in_stall),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.end_of_set (end_of_set),
		.overflowed (overflowed),
		.status     (status),
		.cmd        (cmd)
	);

	// box store, window, adjacency test and bounding-box merge
	abm_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.box_left   (box_left),
		.box_top    (box_top),
		.box_width  (box_width),
		.box_height (box_height),
		.box_score  (box_score),
		.cmd        (cmd),
		.status     (status),
		.rd_box     (rd_box)
	);

	// read register holds the emitted word while out_valid is high
	assign out_left   = rd_box.l;
	assign out_top    = rd_box.t;
	assign out_width  = rd_box.w;
	assign out_height = rd_box.h;
	assign out_score  = rd_box.s;

endmodule

/* rtl/abm_dp.sv */
`timescale 1ns / 1ps
module abm_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [abm_pkg::REG_IDX_W-1:0]      cfg_index,
	input  logic [abm_pkg::MARGIN_W-1:0]       cfg_data,
	input  logic [abm_pkg::COORD_W-1:0]        box_left,
	input  logic [abm_pkg::COORD_W-1:0]        box_top,
	input  logic [abm_pkg::COORD_W-1:0]        box_width,
	input  logic [abm_pkg::COORD_W-1:0]        box_height,
	input  logic [abm_pkg::SCORE_W-1:0]        box_score,
	input  abm_pkg::cmd_t                      cmd,
	output abm_pkg::status_t                   status,
	output abm_pkg::box_t                      rd_box
);

	localparam int CW = abm_pkg::COORD_W + 3;

	logic [abm_pkg::MARGIN_W-1:0] margin_x_q;
	logic [abm_pkg::MARGIN_W-1:0] margin_y_q;

	abm_pkg::box_t mem_q [abm_pkg::MAX_BOXES];
	abm_pkg::box_t rdata_q;
	abm_pkg::box_t a_q;
	abm_pkg::box_t wdata;
	abm_pkg::box_t merged;

	logic signed [CW-1:0] wx_lo_q, wx_hi_q, wy_lo_q, wy_hi_q;
	logic                 hit_q;
	logic                 hit_d;

	logic [abm_pkg::COORD_W:0] a_r, b_r, a_b, b_b, right, bottom, w_sum, h_sum;
	logic [abm_pkg::COORD_W-1:0] left, top;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_x_q <= abm_pkg::MARGIN_X_RST;
			margin_y_q <= abm_pkg::MARGIN_Y_RST;
		end else if (cfg_wr_en) begin
			unique case (abm_pkg::reg_idx_t'(cfg_index))
				abm_pkg::REG_MARGIN_X: margin_x_q <= cfg_data;
				abm_pkg::REG_MARGIN_Y: margin_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cmd.wr_sel)
			abm_pkg::WR_IN:   wdata = '{l: box_left, t: box_top, w: box_width,
				h: box_height, s: box_score};
			abm_pkg::WR_A:    wdata = a_q;
			abm_pkg::WR_MOVE: wdata = rdata_q;
			default:          wdata = rdata_q;
		endcase
	end

	// box store, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (cmd.wr_en)
			mem_q[cmd.wr_addr] <= wdata;
		if (cmd.rd_en)
			rdata_q <= mem_q[cmd.rd_addr];
	end

	// adjacency test against the window frozen at the start of the inner scan
	always_comb begin
		hit_d = ($signed(CW'(rdata_q.l) + CW'(rdata_q.w)) >= wx_lo_q)
			&& ($signed(CW'(rdata_q.l)) <= wx_hi_q)
			&& ($signed(CW'(rdata_q.t) + CW'(rdata_q.h)) >= wy_lo_q)
			&& ($signed(CW'(rdata_q.t)) <= wy_hi_q);
	end

	// bounding box of A and B
	always_comb begin
		a_r    = {1'b0, a_q.l} + {1'b0, a_q.w};
		b_r    = {1'b0, rdata_q.l} + {1'b0, rdata_q.w};
		a_b    = {1'b0, a_q.t} + {1'b0, a_q.h};
		b_b    = {1'b0, rdata_q.t} + {1'b0, rdata_q.h};
		right  = (a_r > b_r) ? a_r : b_r;
		bottom = (a_b > b_b) ? a_b : b_b;
		left   = (a_q.l < rdata_q.l) ? a_q.l : rdata_q.l;
		top    = (a_q.t < rdata_q.t) ? a_q.t : rdata_q.t;
		w_sum  = right - {1'b0, left};
		h_sum  = bottom - {1'b0, top};
		merged.l = left;
		merged.t = top;
		merged.w = w_sum[abm_pkg::COORD_W] ? abm_pkg::SIZE_MAX : w_sum[abm_pkg::COORD_W-1:0];
		merged.h = h_sum[abm_pkg::COORD_W] ? abm_pkg::SIZE_MAX : h_sum[abm_pkg::COORD_W-1:0];
		merged.s = (a_q.s > rdata_q.s) ? a_q.s : rdata_q.s;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_a) begin
			a_q     <= rdata_q;
			wx_lo_q <= $signed(CW'(rdata_q.l)) - $signed(CW'(margin_x_q));
			wx_hi_q <= $signed(CW'(rdata_q.l) + CW'(rdata_q.w) + CW'(margin_x_q));
			wy_lo_q <= $signed(CW'(rdata_q.t)) - $signed(CW'(margin_y_q));
			wy_hi_q <= $signed(CW'(rdata_q.t) + CW'(rdata_q.h) + CW'(margin_y_q));
		end else if (cmd.merge) begin
			a_q <= merged;
		end
		if (cmd.eval)
			hit_q <= hit_d;
	end

	assign status.hit = hit_q;
	assign rd_box     = rdata_q;

endmodule

/* rtl/abm_ctrl.sv */
`timescale 1ns / 1ps
`include "adjacent_box_merger_defines.svh"
module abm_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             final_box,
	output logic             in_stall,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             end_of_set,
	output logic             overflowed,
	input  abm_pkg::status_t status,
	output abm_pkg::cmd_t    cmd
);

	localparam int CNT_W = abm_pkg::CNT_W;
	localparam int IDX_W = abm_pkg::IDX_W;

	typedef enum logic [8:0] {
		S_LOAD     = 9'b000000001,
		S_OUTER    = 9'b000000010,
		S_A_WAIT   = 9'b000000100,
		S_INNER    = 9'b000001000,
		S_B_WAIT   = 9'b000010000,
		S_B_EVAL   = 9'b000100000,
		S_MOVE     = 9'b001000000,
		S_EMIT_RD  = 9'b010000000,
		S_EMIT_OUT = 9'b100000000
	} state_t;

	state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d, i_q, i_d, j_q, j_d, k_q, k_d;
	logic             restart_q, restart_d, drop_q, drop_d;
	logic [CNT_W-1:0] cnt_m1;
	logic             in_acc;

	assign cnt_m1     = cnt_q - 1'b1;
	assign in_stall   = (state_q != S_LOAD);
	assign in_acc     = in_valid && (state_q == S_LOAD);
	assign out_valid  = (state_q == S_EMIT_OUT);
	assign end_of_set = (k_q == cnt_m1);
	assign overflowed = drop_q;

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		i_d       = i_q;
		j_d       = j_q;
		k_d       = k_q;
		restart_d = restart_q;
		drop_d    = drop_q;
		cmd       = '0;
		cmd.wr_sel = abm_pkg::WR_IN;

		unique case (state_q)
			S_LOAD: begin
				if (in_acc) begin
					if (cnt_q < CNT_W'(abm_pkg::MAX_BOXES)) begin
						cmd.wr_en   = 1'b1;
						cmd.wr_addr = cnt_q[IDX_W-1:0];
						cnt_d       = cnt_q + 1'b1;
					end else begin
						drop_d = 1'b1;
					end
					if (final_box) begin
						i_d     = '0;
						state_d = S_OUTER;
					end
				end
			end
			S_OUTER: begin
				if (i_q < cnt_q) begin
					cmd.rd_en   = 1'b1;
					cmd.rd_addr = i_q[IDX_W-1:0];
					state_d     = S_A_WAIT;
				end else begin
					k_d     = '0;
					state_d = S_EMIT_RD;
				end
			end
			S_A_WAIT: begin
				cmd.load_a = 1'b1;
				restart_d  = 1'b0;
				j_d        = i_q + 1'b1;
				state_d    = S_INNER;
			end
			S_INNER: begin
				if (j_q < cnt_q) begin
					cmd.rd_en   = 1'b1;
					cmd.rd_addr = j_q[IDX_W-1:0];
					state_d     = S_B_WAIT;
				end else begin
					// write A back, restart the outer scan after any merge
					cmd.wr_en   = 1'b1;
					cmd.wr_addr = i_q[IDX_W-1:0];
					cmd.wr_sel  = abm_pkg::WR_A;
					i_d         = restart_q ? '0 : i_q + 1'b1;
					state_d     = S_OUTER;
				end
			end
			S_B_WAIT: begin
				cmd.eval = 1'b1;
				state_d  = S_B_EVAL;
			end
			S_B_EVAL: begin
				if (status.hit) begin
					cmd.merge = 1'b1;
					cnt_d     = cnt_m1;
					restart_d = 1'b1;
					if (j_q != cnt_m1) begin
						cmd.rd_en   = 1'b1;
						cmd.rd_addr = cnt_m1[IDX_W-1:0];
						state_d     = S_MOVE;
					end else begin
						j_d     = j_q + 1'b1;
						state_d = S_INNER;
					end
				end else begin
					j_d     = j_q + 1'b1;
					state_d = S_INNER;
				end
			end
			S_MOVE: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_addr = j_q[IDX_W-1:0];
				cmd.wr_sel  = abm_pkg::WR_MOVE;
				j_d         = j_q + 1'b1;
				state_d     = S_INNER;
			end
			S_EMIT_RD: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_addr = k_q[IDX_W-1:0];
				state_d     = S_EMIT_OUT;
			end
			S_EMIT_OUT: begin
				if (!out_stall) begin
					if (end_of_set) begin
						cnt_d   = '0;
						drop_d  = 1'b0;
						state_d = S_LOAD;
					end else begin
						k_d     = k_q + 1'b1;
						state_d = S_EMIT_RD;
					end
				end
			end
			default: state_d = S_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_LOAD;
			cnt_q     <= '0;
			i_q       <= '0;
			j_q       <= '0;
			k_q       <= '0;
			restart_q <= 1'b0;
			drop_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			cnt_q     <= cnt_d;
			i_q       <= i_d;
			j_q       <= j_d;
			k_q       <= k_d;
			restart_q <= restart_d;
			drop_q    <= drop_d;
		end
	end

	`ABM_ASSERT(a_cnt_cap, cnt_q <= CNT_W'(abm_pkg::MAX_BOXES), "box count above capacity")
	`ABM_ASSERT(a_inner_order, (state_q == S_INNER) |-> (j_q > i_q), "inner index not past outer")
	`ABM_ASSERT(a_merge_shrink, (state_q == S_B_EVAL && status.hit) |=> (cnt_q == $past(cnt_q) - 1'b1), "merge did not drop count")
	`ABM_ASSERT(a_emit_range, out_valid |-> (k_q < cnt_q), "emit index beyond live count")

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
	import abm_pkg::*;

	// Each side idles in about this many cycles of a hundred.
	localparam int IDLE_PCT    = 23;
	// Quiet cycles before a register write and at the end of the run.
	localparam int SETTLE      = 4;
	localparam int TAIL        = 40;
	// The limit is far above the slowest legal run, stalls included.
	localparam int CYCLE_LIMIT = 2_000_000;

	// One merged rectangle as it should leave the block.
	typedef struct packed {
		box_t rect;
		logic eos;
		logic ovf;
	} merged_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [MARGIN_W-1:0]  cfg_data;
	logic                 in_valid;
	logic                 in_stall;
	logic [COORD_W-1:0]   box_left;
	logic [COORD_W-1:0]   box_top;
	logic [COORD_W-1:0]   box_width;
	logic [COORD_W-1:0]   box_height;
	logic [SCORE_W-1:0]   box_score;
	logic                 final_box;
	logic                 out_valid;
	logic                 out_stall;
	logic [COORD_W-1:0]   out_left;
	logic [COORD_W-1:0]   out_top;
	logic [COORD_W-1:0]   out_width;
	logic [COORD_W-1:0]   out_height;
	logic [SCORE_W-1:0]   out_score;
	logic                 end_of_set;
	logic                 overflowed;

	adjacent_box_merger u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.box_left   (box_left),
		.box_top    (box_top),
		.box_width  (box_width),
		.box_height (box_height),
		.box_score  (box_score),
		.final_box  (final_box),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_left   (out_left),
		.out_top    (out_top),
		.out_width  (out_width),
		.out_height (out_height),
		.out_score  (out_score),
		.end_of_set (end_of_set),
		.overflowed (overflowed)
	);

	// Predictor state: the set being collected, the drop flag and the margins.
	box_t    pend_boxes [MAX_BOXES];
	int      pend_cnt;
	bit      pend_dropped;
	int      margin_x_cur;
	int      margin_y_cur;
	merged_t merged_q[$];   // merged rectangles still owed by the block

	bit      no_gaps;       // set during the stretch with no idling on either side
	int      cycles;
	int      mismatches;
	int      n_words;
	int      n_sets;
	int      n_results;
	int      n_absorbed;
	int      n_drop_sets;
	merged_t head;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still owed", cycles,
				merged_q.size());
			$display("FAIL");
			$finish;
		end
	end

	// Pairwise merge of the collected set, same loop order as the block:
	// the window of the outer entry is frozen for the whole inner scan, the
	// entry pulled into a freed slot is skipped in that scan, and any merge
	// sends the outer scan back to entry 0.
	function automatic void merge_pending();
		int   n, i, j;
		int   wx, wy, ww, wh;
		int   la, ta, ra, ba, lb, tb, rb, bb;
		int   lo_x, hi_x, lo_y, hi_y;
		bit   again;
		box_t a, b, tmp;
		n = pend_cnt;
		i = 0;
		while (i < n) begin
			wx = int'(pend_boxes[i].l) - margin_x_cur;
			wy = int'(pend_boxes[i].t) - margin_y_cur;
			ww = int'(pend_boxes[i].w) + 2 * margin_x_cur;
			wh = int'(pend_boxes[i].h) + 2 * margin_y_cur;
			again = 1'b0;
			for (j = i + 1; j < n; j++) begin
				a = pend_boxes[i];
				b = pend_boxes[j];
				lb = int'(b.l);
				tb = int'(b.t);
				if (wx - int'(b.w) <= lb && lb <= wx + ww &&
				    wy - int'(b.h) <= tb && tb <= wy + wh) begin
					la = int'(a.l);
					ta = int'(a.t);
					ra = la + int'(a.w);
					ba = ta + int'(a.h);
					rb = lb + int'(b.w);
					bb = tb + int'(b.h);
					lo_x = (la < lb) ? la : lb;
					hi_x = (ra > rb) ? ra : rb;
					lo_y = (ta < tb) ? ta : tb;
					hi_y = (ba > bb) ? ba : bb;
					pend_boxes[i].l = lo_x[COORD_W-1:0];
					pend_boxes[i].t = lo_y[COORD_W-1:0];
					pend_boxes[i].w = (hi_x - lo_x > int'(SIZE_MAX)) ? SIZE_MAX
						: COORD_W'(hi_x - lo_x);
					pend_boxes[i].h = (hi_y - lo_y > int'(SIZE_MAX)) ? SIZE_MAX
						: COORD_W'(hi_y - lo_y);
					if (b.s > a.s)
						pend_boxes[i].s = b.s;
					n--;
					// refill the freed slot with the last live entry
					if (j != n) begin
						tmp = pend_boxes[n];
						pend_boxes[n] = pend_boxes[j];
						pend_boxes[j] = tmp;
					end
					n_absorbed++;
					again = 1'b1;
				end
			end
			i = again ? 0 : i + 1;
		end
		pend_cnt = n;
	endfunction

	// One accepted word: store it (or drop it when full); a final word
	// triggers the merge and queues the survivors in store order.
	function automatic void take_box(input box_t b, input bit last);
		int k;
		if (pend_cnt < MAX_BOXES) begin
			pend_boxes[pend_cnt] = b;
			pend_cnt++;
		end else begin
			pend_dropped = 1'b1;
		end
		if (!last)
			return;
		merge_pending();
		for (k = 0; k < pend_cnt; k++)
			merged_q.insert(merged_q.size(), merged_t'{rect: pend_boxes[k],
				eos: (k == pend_cnt - 1), ovf: pend_dropped});
		if (pend_dropped)
			n_drop_sets++;
		n_sets++;
		pend_cnt = 0;
		pend_dropped = 1'b0;
	endfunction

	function automatic box_t box_of(input int l, t, w, h, s);
		box_t b;
		b.l = COORD_W'(l);
		b.t = COORD_W'(t);
		b.w = COORD_W'(w);
		b.h = COORD_W'(h);
		b.s = SCORE_W'(s);
		return b;
	endfunction

	// Full-range rectangle: every bit of every field gets exercised.
	function automatic box_t any_box();
		return box_of($urandom_range(4095), $urandom_range(4095), $urandom_range(4095),
			$urandom_range(4095), $urandom_range(255));
	endfunction

	// Small rectangle near (cx, cy): these are the ones that actually merge.
	function automatic box_t near_box(input int cx, cy);
		return box_of(cx + $urandom_range(160), cy + $urandom_range(160),
			$urandom_range(48), $urandom_range(48), $urandom_range(255));
	endfunction

	// Send one word. valid stays high on return so back-to-back words keep
	// a single assignment per edge; gaps drop it first.
	task automatic send_box(input box_t b, input bit last);
		while (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		box_left   <= b.l;
		box_top    <= b.t;
		box_width  <= b.w;
		box_height <= b.h;
		box_score  <= b.s;
		final_box  <= last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		take_box(b, last);
		n_words++;
	endtask

	task automatic send_set(input int size, input bit clustered);
		int   k, cx, cy;
		box_t b;
		cx = $urandom_range(3800);
		cy = $urandom_range(3800);
		for (k = 0; k < size; k++) begin
			// a stray full-range box now and then, even in a cluster
			b = (clustered && $urandom_range(9) != 0) ? near_box(cx, cy) : any_box();
			send_box(b, k == size - 1);
		end
	endtask

	// Park the input and wait until every owed result is out, then a few
	// quiet cycles so the block is surely back at rest.
	task automatic wait_idle(input int settle);
		in_valid <= 1'b0;
		while (merged_q.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_margin(input reg_idx_t idx, input logic [MARGIN_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		if (idx == REG_MARGIN_X)
			margin_x_cur = int'(val);
		else
			margin_y_cur = int'(val);
	endtask

	// Single-box sets at both ends of every field.
	task automatic test_lone_boxes();
		send_box(box_of(4095, 4095, 4095, 4095, 255), 1'b1);
		send_box(box_of(0, 0, 0, 0, 0), 1'b1);
	endtask

	// Two boxes apart in x but within the reset x margin; the second has the higher score.
	task automatic test_pair_merge();
		send_box(box_of(100, 100, 20, 20, 10), 1'b0);
		send_box(box_of(130, 105, 10, 10, 200), 1'b1);
	endtask

	// Bounding box wider and taller than 4095 must clamp.
	task automatic test_size_saturation();
		send_box(box_of(0, 0, 4095, 4095, 5), 1'b0);
		send_box(box_of(4000, 4000, 4095, 4095, 7), 1'b1);
	endtask

	// Chain along one row: merges pull the far box forward into a freed slot,
	// and the frozen window misses neighbors until the outer scan restarts.
	task automatic test_stale_window();
		send_box(box_of(0, 50, 10, 10, 1), 1'b0);
		send_box(box_of(20, 50, 10, 10, 9), 1'b0);
		send_box(box_of(40, 50, 10, 10, 4), 1'b0);
		send_box(box_of(60, 50, 10, 10, 3), 1'b0);
		send_box(box_of(500, 900, 10, 10, 2), 1'b1);
	endtask

	// Zero and full margins, with boxes right on and just past the window edge.
	task automatic test_margin_extremes();
		wait_idle(SETTLE);
		write_margin(REG_MARGIN_X, 8'd0);
		write_margin(REG_MARGIN_Y, 8'd0);
		send_box(box_of(100, 100, 10, 10, 30), 1'b0);
		send_box(box_of(110, 100, 5, 5, 20), 1'b1);
		send_box(box_of(100, 100, 10, 10, 30), 1'b0);
		send_box(box_of(111, 100, 5, 5, 20), 1'b1);
		wait_idle(SETTLE);
		write_margin(REG_MARGIN_X, 8'd255);
		write_margin(REG_MARGIN_Y, 8'd255);
		send_box(box_of(0, 0, 1, 1, 0), 1'b0);
		send_box(box_of(256, 256, 1, 1, 255), 1'b1);
		send_box(box_of(1000, 1000, 1, 1, 77), 1'b0);
		send_box(box_of(734, 1000, 10, 1, 78), 1'b1);
	endtask

	// Random well-formed sets, mostly small, sometimes up to a full store.
	task automatic test_random_sets(input logic [MARGIN_W-1:0] mx, my, input int n_box,
		input bit calm);
		int size, sent;
		wait_idle(SETTLE);
		write_margin(REG_MARGIN_X, mx);
		write_margin(REG_MARGIN_Y, my);
		no_gaps = calm;
		sent = 0;
		while (sent < n_box) begin
			size = ($urandom_range(99) < 10) ? $urandom_range(9, 32) : $urandom_range(1, 8);
			send_set(size, $urandom_range(3) != 0);
			sent += size;
		end
		no_gaps = 1'b0;
	endtask

	// Exactly full store, then two past capacity so the final word is dropped
	// yet still starts the merge.
	task automatic test_capacity();
		wait_idle(SETTLE);
		write_margin(REG_MARGIN_X, MARGIN_W'($urandom_range(255)));
		write_margin(REG_MARGIN_Y, MARGIN_W'($urandom_range(255)));
		send_set(MAX_BOXES, 1'b1);
		send_set(MAX_BOXES + 2, 1'b1);
	endtask

	task automatic check_field(input string name, input logic [COORD_W-1:0] got, want);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%s wrong on result %0d: expected %0d, got %0d", name, n_results,
					want, got);
		end
	endtask

	// Output side: take each result against the oldest owed rectangle, and
	// throw random stalls at the block.
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			n_results++;
			if (merged_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d with nothing owed: %0d,%0d %0dx%0d score %0d",
						n_results, out_left, out_top, out_width, out_height, out_score);
			end else begin
				head = merged_q.pop_front();
				check_field("out_left", out_left, head.rect.l);
				check_field("out_top", out_top, head.rect.t);
				check_field("out_width", out_width, head.rect.w);
				check_field("out_height", out_height, head.rect.h);
				check_field("out_score", COORD_W'(out_score), COORD_W'(head.rect.s));
				check_field("end_of_set", COORD_W'(end_of_set), COORD_W'(head.eos));
				check_field("overflowed", COORD_W'(overflowed), COORD_W'(head.ovf));
			end
		end
		out_stall <= arst_n && !no_gaps && ($urandom_range(99) < IDLE_PCT);
	end

	initial begin
		arst_n       = 1'b0;
		cfg_wr_en    = 1'b0;
		cfg_index    = REG_MARGIN_X;
		cfg_data     = '0;
		in_valid     = 1'b0;
		box_left     = '0;
		box_top      = '0;
		box_width    = '0;
		box_height   = '0;
		box_score    = '0;
		final_box    = 1'b0;
		out_stall    = 1'b0;
		no_gaps      = 1'b0;
		cycles       = 0;
		mismatches   = 0;
		n_words      = 0;
		n_sets       = 0;
		n_results    = 0;
		n_absorbed   = 0;
		n_drop_sets  = 0;
		pend_cnt     = 0;
		pend_dropped = 1'b0;
		margin_x_cur = int'(MARGIN_X_RST);
		margin_y_cur = int'(MARGIN_Y_RST);
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset margins (16, 0) first
		test_lone_boxes();
		test_pair_merge();
		test_size_saturation();
		test_stale_window();
		test_margin_extremes();
		test_random_sets(8'd255, 8'd255, 48, 1'b0);
		test_random_sets(8'd0, 8'd0, 48, 1'b0);
		test_random_sets(MARGIN_X_RST, MARGIN_Y_RST, 48, 1'b1);
		test_random_sets(MARGIN_W'($urandom_range(255)), MARGIN_W'($urandom_range(255)), 48,
			1'b0);
		test_capacity();

		wait_idle(TAIL);
		$display("sent %0d words in %0d sets; checked %0d merged rectangles", n_words, n_sets,
			n_results);
		$display("%0d boxes absorbed by merging, %0d sets overran the store, %0d mismatches",
			n_absorbed, n_drop_sets, mismatches);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
